// File: rtl/circle_outside_mask_spans_top_defines.svh
// Assertion macros used by the span output stage of the circle mask span RTL.
`ifndef CIRCLE_OUTSIDE_MASK_SPANS_TOP_DEFINES_SVH
`define CIRCLE_OUTSIDE_MASK_SPANS_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define COMS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("coms assertion failed");

// Next-cycle implication, disabled during reset.
`define COMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("coms assertion failed");

`else

`define COMS_ASSERT_NOW(label, clk, rst, ante, cons)
`define COMS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/coms_pkg.sv
// Shared types and constants for the circle mask span generator.
package coms_pkg;

  // Default screen geometry.
  localparam int DEF_SCREEN_WIDTH  = 1920;
  localparam int DEF_SCREEN_HEIGHT = 1080;

  // Field widths.
  localparam int COORD_W  = 12;
  localparam int RADIUS_W = 13;
  localparam int LEN_W    = 13;
  localparam int ROOT_W   = 13;
  localparam int REM_W    = 2 * ROOT_W;
  localparam int IDX_W    = 2;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_CTR_COL = 2'd0;
  localparam logic [IDX_W-1:0] REG_CTR_ROW = 2'd1;
  localparam logic [IDX_W-1:0] REG_RADIUS  = 2'd2;

  // Configuration reset values.
  localparam logic [COORD_W-1:0]  RST_CTR_COL = 12'd960;
  localparam logic [COORD_W-1:0]  RST_CTR_ROW = 12'd540;
  localparam logic [RADIUS_W-1:0] RST_RADIUS  = 13'd0;

  // Control word that travels with each item down the pipeline.
  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] row;
    logic               full;
    logic               off;
  } pipe_ctl_t;

endpackage

// File: rtl/coms_front.sv
// Front stages: row classification, squaring and radicand forming.
module coms_front import coms_pkg::*; #(
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                load,
  input  logic [COORD_W-1:0]  row,
  input  logic [COORD_W-1:0]  ctr_row,
  input  logic [RADIUS_W-1:0] radius,
  output pipe_ctl_t           ctl_out,
  output logic [REM_W-1:0]    rem_out
);

  localparam logic [COORD_W:0] HEIGHT_C = (COORD_W+1)'(SCREEN_HEIGHT);

  logic [COORD_W:0]   diff;
  logic [COORD_W-1:0] dy_abs_next;
  pipe_ctl_t          ctl_next;

  pipe_ctl_t            ctl1;
  logic [COORD_W-1:0]   dy_abs;
  pipe_ctl_t            ctl2;
  logic [REM_W-1:0]     sq_r;
  logic [2*COORD_W-1:0] sq_dy;

  // Distance from the center row and range checks.
  always_comb begin
    diff              = {1'b0, row} - {1'b0, ctr_row};
    dy_abs_next       = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
    ctl_next.valid    = load;
    ctl_next.row      = row;
    ctl_next.off      = ({1'b0, row} >= HEIGHT_C);
    ctl_next.full     = (radius == '0) || ({1'b0, dy_abs_next} > radius);
  end

  // Stage one: classified row.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
    end else if (en) begin
      ctl1.valid <= ctl_next.valid;
    end
    if (en) begin
      ctl1.row  <= ctl_next.row;
      ctl1.full <= ctl_next.full;
      ctl1.off  <= ctl_next.off;
      dy_abs    <= dy_abs_next;
    end
  end

  // Stage two: both squares.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2.valid <= 1'b0;
    end else if (en) begin
      ctl2.valid <= ctl1.valid;
    end
    if (en) begin
      ctl2.row  <= ctl1.row;
      ctl2.full <= ctl1.full;
      ctl2.off  <= ctl1.off;
      sq_r      <= radius * radius;
      sq_dy     <= dy_abs * dy_abs;
    end
  end

  // Stage three: radicand for the half width.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl2.valid;
    end
    if (en) begin
      ctl_out.row  <= ctl2.row;
      ctl_out.full <= ctl2.full;
      ctl_out.off  <= ctl2.off;
      rem_out      <= sq_r - {{(REM_W-2*COORD_W){1'b0}}, sq_dy};
    end
  end

endmodule

// File: rtl/coms_sqrt_cell.sv
// One cell of the square root chain: decides one bit of the root.
module coms_sqrt_cell import coms_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  pipe_ctl_t         ctl_in,
  input  logic [REM_W-1:0]  rem_in,
  input  logic [ROOT_W-1:0] root_in,
  output pipe_ctl_t         ctl_out,
  output logic [REM_W-1:0]  rem_out,
  output logic [ROOT_W-1:0] root_out
);

  logic [REM_W:0]    trial;
  logic              take;
  logic [REM_W-1:0]  rem_next;
  logic [ROOT_W-1:0] root_next;

  // Trial subtrahend is (2q + 2^BIT) * 2^BIT with q holding the bits above BIT.
  always_comb begin
    trial     = ((REM_W+1)'(root_in) << (BIT + 1)) | ((REM_W+1)'(1) << (2 * BIT));
    take      = ({1'b0, rem_in} >= trial);
    rem_next  = take ? REM_W'({1'b0, rem_in} - trial) : rem_in;
    root_next = take ? (root_in | (ROOT_W'(1) << BIT)) : root_in;
  end

  // Hand the partial result to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_out.row  <= ctl_in.row;
      ctl_out.full <= ctl_in.full;
      ctl_out.off  <= ctl_in.off;
      rem_out      <= rem_next;
      root_out     <= root_next;
    end
  end

endmodule

// File: rtl/coms_span.sv
// Span forming and output stage with a one-entry hold for the second span.
`include "circle_outside_mask_spans_top_defines.svh"

module coms_span import coms_pkg::*; #(
  parameter int SCREEN_WIDTH = DEF_SCREEN_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  pipe_ctl_t          ctl,
  input  logic [ROOT_W-1:0]  root,
  input  logic [COORD_W-1:0] ctr_col,
  output logic               advance,
  output logic               busy,
  output logic               result_valid,
  output logic [COORD_W-1:0] span_row,
  output logic [COORD_W-1:0] span_start,
  output logic [LEN_W-1:0]   span_length,
  output logic               last_span
);

  localparam logic [LEN_W-1:0] WIDTH_C    = LEN_W'(SCREEN_WIDTH);
  localparam logic [LEN_W:0]   WIDTH_M1_C = (LEN_W+1)'(SCREEN_WIDTH - 1);

  logic [LEN_W:0]     left;
  logic [LEN_W:0]     right;
  logic               left_hit;
  logic               right_hit;
  logic [LEN_W-1:0]   left_len;
  logic [COORD_W-1:0] right_start;
  logic [LEN_W-1:0]   right_len;
  logic               any_span;
  logic               two_spans;
  logic               first_last;
  logic [COORD_W-1:0] first_start;
  logic [LEN_W-1:0]   first_len;

  logic               pend_valid;
  logic [COORD_W-1:0] pend_start;
  logic [LEN_W-1:0]   pend_len;

  // Edges of the circle on this row and the spans outside it.
  always_comb begin
    left        = {2'b00, ctr_col} - {1'b0, root};
    right       = {2'b00, ctr_col} + {1'b0, root};
    left_hit    = !left[LEN_W] && (left != '0);
    left_len    = (left[LEN_W-1:0] > WIDTH_C) ? WIDTH_C : left[LEN_W-1:0];
    right_hit   = (right < WIDTH_M1_C);
    right_start = COORD_W'(right + 1'b1);
    right_len   = WIDTH_C - {1'b0, right_start};
  end

  // Pick the first span of the item and whether a second one follows.
  always_comb begin
    any_span    = 1'b0;
    two_spans   = 1'b0;
    first_last  = 1'b1;
    first_start = '0;
    first_len   = WIDTH_C;
    if (ctl.off) begin
      any_span = 1'b0;
    end else if (ctl.full) begin
      any_span = 1'b1;
    end else if (left_hit) begin
      any_span   = 1'b1;
      first_len  = left_len;
      two_spans  = right_hit;
      first_last = !right_hit;
    end else if (right_hit) begin
      any_span    = 1'b1;
      first_start = right_start;
      first_len   = right_len;
    end
  end

  // The pipeline holds while the second span goes out.
  assign advance = !pend_valid;
  assign busy    = pend_valid;

  // Output strobe and the hold flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
    end else if (pend_valid) begin
      result_valid <= 1'b1;
      pend_valid   <= 1'b0;
    end else begin
      result_valid <= ctl.valid && any_span;
      pend_valid   <= ctl.valid && any_span && two_spans;
    end
  end

  // Output payload and the held second span.
  always_ff @(posedge clk) begin
    if (pend_valid) begin
      span_start  <= pend_start;
      span_length <= pend_len;
      last_span   <= 1'b1;
    end else if (ctl.valid) begin
      span_row    <= ctl.row;
      span_start  <= first_start;
      span_length <= first_len;
      last_span   <= first_last;
      pend_start  <= right_start;
      pend_len    <= right_len;
    end
  end

  // A held span goes out in the very next cycle as the row's last one.
  `COMS_ASSERT_NEXT(a_pend_emits, clk, rst, pend_valid, result_valid && last_span)
  // The hold never lasts more than one cycle.
  `COMS_ASSERT_NEXT(a_pend_single, clk, rst, pend_valid, !pend_valid)
  // Every emitted span is non-empty and fits the screen.
  `COMS_ASSERT_NOW(a_len_range, clk, rst, result_valid,
                   (span_length != '0) && (span_length <= WIDTH_C))

endmodule

// File: rtl/circle_outside_mask_spans_top.sv
// Top level of the circle mask span generator.
//
// Usage: drive row with start high; the row is taken at a clock edge where
// start is high and busy is low. For every taken row the block gives zero,
// one or two spans of masked pixels on span_row, span_start, span_length and
// last_span, each marked by result_valid for exactly one cycle; the final
// span of a row carries last_span. Rows at or past the screen height give
// no span. The receiver must take each span in the cycle it is shown.
// A row passes three front stages, thirteen square root cells and one output
// register before its first span goes out. One row is taken per cycle while
// busy is low; for a row with two spans the second goes out from a one-entry
// hold while busy stalls the chain. The half width comes from thirteen cells,
// one root bit each. Configuration (center column, center row, radius) is written
// through wr_en, wr_index and wr_data; the user must do so only while no row is
// in flight, which the block itself does not enforce. Reset restores the register
// defaults and empties the chain; no clearing pass is needed.
module circle_outside_mask_spans_top import coms_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [COORD_W-1:0]  row,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_index,
  input  logic [RADIUS_W-1:0] wr_data,
  output logic                result_valid,
  output logic [COORD_W-1:0]  span_row,
  output logic [COORD_W-1:0]  span_start,
  output logic [LEN_W-1:0]    span_length,
  output logic                last_span
);

  logic [COORD_W-1:0]  ctr_col;
  logic [COORD_W-1:0]  ctr_row;
  logic [RADIUS_W-1:0] radius;

  logic advance;
  logic load;

  pipe_ctl_t         chain_ctl  [ROOT_W+1];
  logic [REM_W-1:0]  chain_rem  [ROOT_W+1];
  logic [ROOT_W-1:0] chain_root [ROOT_W+1];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctr_col <= RST_CTR_COL;
      ctr_row <= RST_CTR_ROW;
      radius  <= RST_RADIUS;
    end else if (wr_en) begin
      case (wr_index)
        REG_CTR_COL: ctr_col <= wr_data[COORD_W-1:0];
        REG_CTR_ROW: ctr_row <= wr_data[COORD_W-1:0];
        REG_RADIUS:  radius  <= wr_data;
        default: ;
      endcase
    end
  end

  assign load = start && !busy;

  // Row classification and radicand.
  coms_front #(
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .load     (load),
    .row      (row),
    .ctr_row  (ctr_row),
    .radius   (radius),
    .ctl_out  (chain_ctl[0]),
    .rem_out  (chain_rem[0])
  );

  assign chain_root[0] = '0;

  // Square root chain, most significant root bit first.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
    coms_sqrt_cell #(
      .BIT(ROOT_W - 1 - k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (advance),
      .ctl_in   (chain_ctl[k]),
      .rem_in   (chain_rem[k]),
      .root_in  (chain_root[k]),
      .ctl_out  (chain_ctl[k+1]),
      .rem_out  (chain_rem[k+1]),
      .root_out (chain_root[k+1])
    );
  end

  // Span forming and output.
  coms_span #(
    .SCREEN_WIDTH(SCREEN_WIDTH)
  ) u_span (
    .clk          (clk),
    .rst          (rst),
    .ctl          (chain_ctl[ROOT_W]),
    .root         (chain_root[ROOT_W]),
    .ctr_col      (ctr_col),
    .advance      (advance),
    .busy         (busy),
    .result_valid (result_valid),
    .span_row     (span_row),
    .span_start   (span_start),
    .span_length  (span_length),
    .last_span    (last_span)
  );

endmodule

// File: tb/circle_outside_mask_spans_top_tb.sv
// Testbench for the circle mask span generator: row driver, span checker and predictor.
module circle_outside_mask_spans_top_tb import coms_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCREEN_WIDTH  = DEF_SCREEN_WIDTH;
  localparam int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT;
  // Quiet time that lets every taken row leave the chain before a register write.
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 20;
  localparam int ROWS_PER_PHASE = 100;
  // The fourth register index decodes to no register at all.
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

  // One pending operation: a row to send or a register write.
  typedef struct {
    bit                  is_cfg;
    logic [IDX_W-1:0]    idx;
    logic [RADIUS_W-1:0] data;
    logic [COORD_W-1:0]  row_no;
  } stim_op_t;

  // One expected span.
  typedef struct {
    logic [COORD_W-1:0] row_no;
    logic [COORD_W-1:0] start_col;
    logic [LEN_W-1:0]   len;
    logic               last;
  } span_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [COORD_W-1:0]  row = '0;
  logic                wr_en = 1'b0;
  logic [IDX_W-1:0]    wr_index = '0;
  logic [RADIUS_W-1:0] wr_data = '0;
  logic                result_valid;
  logic [COORD_W-1:0]  span_row;
  logic [COORD_W-1:0]  span_start;
  logic [LEN_W-1:0]    span_length;
  logic                last_span;

  stim_op_t pending_ops[$];
  span_t    span_expect_q[$];

  // Predictor's copy of the registers.
  logic [COORD_W-1:0]  cfg_ctr_col;
  logic [COORD_W-1:0]  cfg_ctr_row;
  logic [RADIUS_W-1:0] cfg_radius;

  logic row_taken = 1'b0;
  int   quiet_cycles = 0;
  int   cycle_count = 0;
  int   rows_sent = 0;
  int   rows_taken = 0;
  int   spans_checked = 0;
  int   cfg_writes = 0;
  int   mismatches = 0;
  int   rows_by_spans[3] = '{0, 0, 0};

  circle_outside_mask_spans_top #(
    .SCREEN_WIDTH(SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .row(row),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .result_valid(result_valid),
    .span_row(span_row),
    .span_start(span_start),
    .span_length(span_length),
    .last_span(last_span)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Floor square root, one result bit per pass from the top down.
  function automatic int unsigned floor_root(input int unsigned v);
    int unsigned acc;
    int unsigned probe;
    acc = 0;
    probe = 32'd1 << 30;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= acc + probe) begin
        v -= acc + probe;
        acc = (acc >> 1) + probe;
      end else begin
        acc >>= 1;
      end
      probe >>= 2;
    end
    return acc;
  endfunction

  // Work out the spans of one taken row and queue them.
  task automatic predict_spans(input logic [COORD_W-1:0] r_row);
    int          y, cx, cy, rad, dy, half, left_edge, right_edge, first_col, n;
    int unsigned rem;
    span_t       sp[2];
    y = r_row;
    cx = cfg_ctr_col;
    cy = cfg_ctr_row;
    rad = cfg_radius;
    n = 0;
    if (y >= SCREEN_HEIGHT) begin
      rows_by_spans[0]++;
      return;
    end
    // Rows the circle does not reach are masked across the whole width.
    if (rad == 0 || y < cy - rad || y > cy + rad) begin
      span_expect_q.push_back('{r_row, '0, LEN_W'(SCREEN_WIDTH), 1'b1});
      rows_by_spans[1]++;
      return;
    end
    dy = y - cy;
    rem = int'(rad * rad) - int'(dy * dy);
    half = floor_root(rem);
    left_edge = cx - half;
    right_edge = cx + half;
    if (left_edge > 0) begin
      sp[n] = '{r_row, '0,
                LEN_W'(left_edge > SCREEN_WIDTH ? SCREEN_WIDTH : left_edge), 1'b0};
      n++;
    end
    if (right_edge < SCREEN_WIDTH - 1) begin
      first_col = right_edge + 1;
      if (first_col < 0) first_col = 0;
      sp[n] = '{r_row, COORD_W'(first_col), LEN_W'(SCREEN_WIDTH - first_col), 1'b0};
      n++;
    end
    if (n > 0) sp[n - 1].last = 1'b1;
    for (int k = 0; k < n; k++) span_expect_q.push_back(sp[k]);
    rows_by_spans[n]++;
  endtask

  // Driver: rows and register writes change on the falling edge.
  always @(negedge clk) begin
    bit               hold;
    bit               drv_start;
    bit               drv_wr;
    logic [COORD_W-1:0]  drv_row;
    logic [IDX_W-1:0]    drv_idx;
    logic [RADIUS_W-1:0] drv_data;
    bit               no_idle;
    stim_op_t         head;
    if (!rst) begin
      hold = start && !row_taken;
      if (!hold) begin
        drv_start = 1'b0;
        drv_wr = 1'b0;
        drv_row = COORD_W'($urandom_range(0, 4095));
        drv_idx = IDX_W'($urandom_range(0, 3));
        drv_data = RADIUS_W'($urandom_range(0, 8191));
        no_idle = rows_sent >= 900 && rows_sent < 1200;
        if (pending_ops.size() != 0 && (no_idle || $urandom_range(0, 99) >= 17)) begin
          head = pending_ops[0];
          if (head.is_cfg) begin
            // Registers change only once the chain has drained.
            if (span_expect_q.size() == 0 && quiet_cycles >= DRAIN_CYCLES) begin
              drv_wr = 1'b1;
              drv_idx = head.idx;
              drv_data = head.data;
              void'(pending_ops.pop_front());
            end
          end else begin
            drv_start = 1'b1;
            drv_row = head.row_no;
            rows_sent++;
            void'(pending_ops.pop_front());
          end
        end
        start <= drv_start;
        row <= drv_row;
        wr_en <= drv_wr;
        wr_index <= drv_idx;
        wr_data <= drv_data;
      end
    end
  end

  // Monitor: check spans, track registers and predict taken rows.
  always @(posedge clk) begin
    span_t exp_span;
    cycle_count++;
    if (rst) begin
      cfg_ctr_col = RST_CTR_COL;
      cfg_ctr_row = RST_CTR_ROW;
      cfg_radius = RST_RADIUS;
      quiet_cycles = 0;
      row_taken <= 1'b0;
    end else begin
      if (result_valid) begin
        spans_checked++;
        if (span_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected span row %0d start %0d length %0d",
                                    span_row, span_start, span_length));
        end else begin
          exp_span = span_expect_q.pop_front();
          if (span_row !== exp_span.row_no)
            report_mismatch($sformatf("span_row got %0d want %0d",
                                      span_row, exp_span.row_no));
          if (span_start !== exp_span.start_col)
            report_mismatch($sformatf("span_start got %0d want %0d (row %0d)",
                                      span_start, exp_span.start_col, exp_span.row_no));
          if (span_length !== exp_span.len)
            report_mismatch($sformatf("span_length got %0d want %0d (row %0d)",
                                      span_length, exp_span.len, exp_span.row_no));
          if (last_span !== exp_span.last)
            report_mismatch($sformatf("last_span got %0b want %0b (row %0d)",
                                      last_span, exp_span.last, exp_span.row_no));
        end
      end
      if (wr_en) begin
        cfg_writes++;
        case (wr_index)
          REG_CTR_COL: cfg_ctr_col = wr_data[COORD_W-1:0];
          REG_CTR_ROW: cfg_ctr_row = wr_data[COORD_W-1:0];
          REG_RADIUS:  cfg_radius = wr_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        predict_spans(row);
        rows_taken++;
        quiet_cycles = 0;
      end else if (quiet_cycles < DRAIN_CYCLES) begin
        quiet_cycles++;
      end
      row_taken <= start && !busy;
    end
  end

  // Cycle limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", cycle_count);
    $display("simulation failed");
    $finish;
  end

  task automatic push_cfg(input logic [IDX_W-1:0] idx, input logic [RADIUS_W-1:0] data);
    pending_ops.push_back('{1'b1, idx, data, '0});
  endtask

  task automatic push_row(input int r);
    pending_ops.push_back('{1'b0, '0, '0, COORD_W'(r)});
  endtask

  // Stimulus: directed corners first, then random circles and rows.
  initial begin
    int gx, gy, gr, lo, hi, mode, sel;
    logic [RADIUS_W-1:0] d;

    // Reset settings, radius zero: every visible row is one full span.
    push_row(0);
    push_row(1079);
    push_row(1080);
    push_row(4095);
    push_row(540);

    // Centered circle: top and bottom edges, just outside, widest row.
    push_cfg(REG_CTR_COL, 13'd960);
    push_cfg(REG_CTR_ROW, 13'd540);
    push_cfg(REG_RADIUS, 13'd300);
    push_row(240);
    push_row(239);
    push_row(840);
    push_row(841);
    push_row(540);
    push_row(541);

    // Largest radius from the corner covers the row: no spans.
    push_cfg(REG_CTR_COL, 13'd0);
    push_cfg(REG_CTR_ROW, 13'd0);
    push_cfg(REG_RADIUS, 13'd8191);
    push_row(0);
    push_row(1079);

    // Centers written with the top data bit set land at 4095.
    push_cfg(REG_CTR_COL, 13'h1FFF);
    push_cfg(REG_CTR_ROW, 13'h1FFF);
    push_cfg(REG_SPARE, 13'h1ABC);
    push_row(0);
    push_row(1079);

    // Small circle at the left edge, center row still 4095: every row is one full span.
    push_cfg(REG_CTR_COL, 13'd0);
    push_cfg(REG_RADIUS, 13'd5);
    push_row(0);
    push_row(5);
    push_row(6);

    // Circle touching the right edge: only a left span.
    push_cfg(REG_CTR_COL, 13'd1919);
    push_cfg(REG_CTR_ROW, 13'd100);
    push_cfg(REG_RADIUS, 13'd1);
    push_row(100);
    push_row(99);
    push_cfg(REG_CTR_COL, 13'd1918);
    push_row(100);

    // Random phases: a new circle, then rows mostly through its extent.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      mode = $urandom_range(0, 9);
      gx = (mode == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 1919);
      gy = (mode == 1) ? $urandom_range(0, 4095) : $urandom_range(0, 1079);
      if (mode == 2) gr = 0;
      else if (mode == 3) gr = $urandom_range(0, 8191);
      else if (mode == 4) gr = $urandom_range(1, 8);
      else gr = $urandom_range(1, 1100);
      d = RADIUS_W'(gx);
      d[RADIUS_W-1] = $urandom_range(0, 1);
      push_cfg(REG_CTR_COL, d);
      d = RADIUS_W'(gy);
      d[RADIUS_W-1] = $urandom_range(0, 1);
      push_cfg(REG_CTR_ROW, d);
      push_cfg(REG_RADIUS, RADIUS_W'(gr));
      if ($urandom_range(0, 9) == 0) push_cfg(REG_SPARE, RADIUS_W'($urandom_range(0, 8191)));
      lo = (gy - gr < 0) ? 0 : gy - gr;
      hi = (gy + gr > SCREEN_HEIGHT - 1) ? SCREEN_HEIGHT - 1 : gy + gr;
      for (int k = 0; k < ROWS_PER_PHASE; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 70 && lo <= hi) push_row($urandom_range(lo, hi));
        else if (sel < 88) push_row($urandom_range(0, SCREEN_HEIGHT - 1));
        else push_row($urandom_range(0, 4095));
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for the last item and its spans, then let the chain drain.
    while (pending_ops.size() != 0 || start || wr_en) @(posedge clk);
    while (span_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Rows taken: %0d (%0d off screen or fully open, %0d one span, %0d two spans).",
             rows_taken, rows_by_spans[0], rows_by_spans[1], rows_by_spans[2]);
    $display("Spans checked: %0d, register writes: %0d, mismatches: %0d.",
             spans_checked, cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
